// ----- hw/rtl/fm_patch_dedup_tracker_unit_defines.svh -----
// assertion macros for the patch dedup tracker
`ifndef FM_PATCH_DEDUP_TRACKER_UNIT_DEFINES_SVH
`define FM_PATCH_DEDUP_TRACKER_UNIT_DEFINES_SVH
`define FPD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define FPD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ----- hw/rtl/fpd_pkg.sv -----
// shared types and constants for the patch dedup tracker
package fpd_pkg;
	localparam int TONE_CAPACITY = 256;
	localparam int TIDX_W = $clog2(TONE_CAPACITY);
	localparam int CNT_W = $clog2(TONE_CAPACITY + 1);
	localparam int NUM_CHANS = 6;
	localparam int OP_BITS = 44 * 7;
	localparam int PATCH_BITS = OP_BITS + 2 * 7;
	localparam logic [7:0] KEY_ON_ADDR = 8'h28;
	localparam logic [5:0] LAST_PARAM = 6'd45;

	typedef enum logic [1:0] {
		KIND_NEW = 2'd0,
		KIND_MATCH = 2'd1,
		KIND_FULL = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_EMIT
	} back_state_t;

	// job handed from front to back
	typedef struct packed {
		logic [2:0] chan;
		logic [PATCH_BITS-1:0] patch;
	} job_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [2:0] channel;
		logic [7:0] tone_index;
		logic [5:0] param_index;
		logic [6:0] param_value;
		logic last;
	} result_t;

	function automatic logic [1:0] op_slot(input logic [1:0] a);
		case (a)
			2'd0: op_slot = 2'd0;
			2'd1: op_slot = 2'd2;
			2'd2: op_slot = 2'd1;
			default: op_slot = 2'd3;
		endcase
	endfunction
endpackage

// ----- hw/rtl/fm_patch_dedup_tracker_unit.sv -----
// top level of the FM patch dedup tracker
// Snoops synthesizer register writes on the in channel (port, address, data).
// Parameter writes update a per-channel shadow.
// A key-on of a changed channel is queued to the back part, which scans the
// patch table at one stored patch per cycle through a registered memory read.
// A full table reports at once without a search.
// A match or full table gives one result item; a new patch is written to the
// table and then gives 46 items, one per cycle while out_ready is high.
// The front keeps taking parameter writes while the back works; a key-on
// waits only when the two-entry queue is full.
// Results sit in an output register; a stalled receiver holds the item and
// backs up the search, then the queue, then in_ready.
// Reset clears shadows, changed flags and the stored count; the table
// itself is not cleared and needs no clearing pass.
module fm_patch_dedup_tracker_unit import fpd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic port,
	input logic [7:0] address,
	input logic [7:0] data,
	output logic out_valid,
	input logic out_ready,
	output logic [1:0] kind,
	output logic [2:0] channel,
	output logic [7:0] tone_index,
	output logic [5:0] param_index,
	output logic [6:0] param_value,
	output logic last
);
	`include "fm_patch_dedup_tracker_unit_defines.svh"

	logic fq_valid, fq_ready, qb_valid, qb_ready;
	job_t fq_job, qb_job;
	result_t res;

	fpd_front u_front (.clk, .arst_n, .in_valid, .in_ready, .port, .address, .data,
		.job_valid(fq_valid), .job_ready(fq_ready), .job(fq_job));
	fpd_queue u_queue (.clk, .arst_n, .wr_valid(fq_valid), .wr_ready(fq_ready),
		.wr_job(fq_job), .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_job(qb_job));
	fpd_back u_back (.clk, .arst_n, .job_valid(qb_valid), .job_ready(qb_ready),
		.job(qb_job), .out_valid, .out_ready, .res);

	assign kind = res.kind;
	assign channel = res.channel;
	assign tone_index = res.tone_index;
	assign param_index = res.param_index;
	assign param_value = res.param_value;
	assign last = res.last;

	`FPD_ASSERT_IMPL(a_kind_range, clk, arst_n, out_valid, kind != 2'd3,
		"bad result kind")
	`FPD_ASSERT_IMPL(a_single_last, clk, arst_n, out_valid && kind != KIND_NEW, last,
		"match or full item without last")
	`FPD_ASSERT_NEXT(a_param_step, clk, arst_n,
		out_valid && out_ready && kind == KIND_NEW && !last,
		!out_valid || param_index == $past(param_index) + 6'd1,
		"parameter run out of order")
endmodule

// ----- hw/rtl/fpd_front.sv -----
// front part: shadow registers, key-on classification
module fpd_front import fpd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic port,
	input logic [7:0] address,
	input logic [7:0] data,
	output logic job_valid,
	input logic job_ready,
	output job_t job
);
	logic [6:0] par_q [NUM_CHANS][46];
	logic [NUM_CHANS-1:0] changed_q;
	logic [2:0] kchan;
	logic kvalid;
	logic [2:0] wchan;
	logic [5:0] base;
	logic is_key;
	logic fire;

	always_comb begin
		case (data[2:0])
			3'd0: kchan = 3'd0;
			3'd1: kchan = 3'd1;
			3'd2: kchan = 3'd2;
			3'd4: kchan = 3'd3;
			3'd5: kchan = 3'd4;
			3'd6: kchan = 3'd5;
			default: kchan = 3'd7;
		endcase
		kvalid = (kchan != 3'd7);
		is_key = (address == KEY_ON_ADDR);
		fire = is_key && kvalid && (data[7:4] != 4'd0) && changed_q[kchan];
		wchan = 3'(3 * {2'd0, port}) + {1'b0, address[1:0]};
		base = 6'(11 * op_slot(address[3:2]));
		in_ready = !fire || job_ready;
		job_valid = in_valid && fire;
		job.chan = kchan;
		for (int p = 0; p < 46; p++) begin
			job.patch[p*7 +: 7] = par_q[kvalid ? kchan : 3'd0][p];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			changed_q <= '0;
			for (int c = 0; c < NUM_CHANS; c++) begin
				for (int p = 0; p < 46; p++) begin
					par_q[c][p] <= '0;
				end
			end
		end else if (in_valid && in_ready && address[1:0] != 2'd3) begin
			if (is_key) begin
				if (fire) begin
					changed_q[kchan] <= 1'b0;
				end
			end else begin
				case (address[7:4])
					4'h3: begin
						par_q[wchan][base + 6'd7] <= {3'd0, data[3:0]};
						par_q[wchan][base + 6'd8] <= {4'd0, data[6:4]};
						changed_q[wchan] <= 1'b1;
					end
					4'h4: begin
						par_q[wchan][base + 6'd5] <= data[6:0];
						changed_q[wchan] <= 1'b1;
					end
					4'h5: begin
						par_q[wchan][base + 6'd6] <= {5'd0, data[7:6]};
						par_q[wchan][base] <= {2'd0, data[4:0]};
						changed_q[wchan] <= 1'b1;
					end
					4'h6: begin
						par_q[wchan][base + 6'd9] <= {6'd0, data[7]};
						par_q[wchan][base + 6'd1] <= {2'd0, data[4:0]};
						changed_q[wchan] <= 1'b1;
					end
					4'h7: begin
						par_q[wchan][base + 6'd2] <= {2'd0, data[4:0]};
						changed_q[wchan] <= 1'b1;
					end
					4'h8: begin
						par_q[wchan][base + 6'd4] <= {3'd0, data[7:4]};
						par_q[wchan][base + 6'd3] <= {3'd0, data[3:0]};
						changed_q[wchan] <= 1'b1;
					end
					4'h9: begin
						par_q[wchan][base + 6'd10] <= {3'd0, data[3:0]};
						changed_q[wchan] <= 1'b1;
					end
					4'hb: begin
						if (address[3:2] == 2'd0) begin
							par_q[wchan][45] <= {4'd0, data[5:3]};
							par_q[wchan][44] <= {4'd0, data[2:0]};
							changed_q[wchan] <= 1'b1;
						end
					end
					default: ;
				endcase
			end
		end
	end
endmodule

// ----- hw/rtl/fpd_queue.sv -----
// two-entry job queue between front and back
module fpd_queue import fpd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic wr_valid,
	output logic wr_ready,
	input job_t wr_job,
	output logic rd_valid,
	input logic rd_ready,
	output job_t rd_job
);
	job_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic wr_en, rd_en;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_job = mem_q[rp_q];
	assign wr_en = wr_valid && wr_ready;
	assign rd_en = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wp_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr_en) wp_q <= !wp_q;
			if (rd_en) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
		end
	end
endmodule

// ----- hw/rtl/fpd_back.sv -----
// back part: patch table search, store and result emission
module fpd_back import fpd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic job_valid,
	output logic job_ready,
	input job_t job,
	output logic out_valid,
	input logic out_ready,
	output result_t res
);
	logic [PATCH_BITS-1:0] tab_q [TONE_CAPACITY];
	logic [PATCH_BITS-1:0] rd_s1;
	back_state_t state_q, state_d;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] idx_q;
	logic rd_ok_s1;
	job_t cur_q;
	logic [5:0] p_q;
	logic ov_q;
	result_t res_q;
	logic take, out_free, hit, done, wr_tab, rd_en;

	assign out_free = !ov_q || out_ready;
	assign out_valid = ov_q;
	assign res = res_q;
	assign hit = rd_ok_s1 && (rd_s1 == cur_q.patch);
	assign done = (idx_q == count_q) && !rd_ok_s1;

	always_comb begin
		state_d = state_q;
		job_ready = 1'b0;
		take = 1'b0;
		wr_tab = 1'b0;
		rd_en = 1'b0;
		case (state_q)
			ST_IDLE: begin
				job_ready = 1'b1;
				if (job_valid) begin
					take = 1'b1;
					state_d = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (count_q == CNT_W'(TONE_CAPACITY) || hit) begin
					if (out_free) state_d = ST_IDLE;
				end else if (done) begin
					state_d = ST_EMIT;
					wr_tab = 1'b1;
				end else if (idx_q != count_q) begin
					rd_en = 1'b1;
				end
			end
			ST_EMIT: begin
				if (out_free && p_q == LAST_PARAM) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (take) cur_q <= job;
		if (wr_tab) tab_q[count_q[TIDX_W-1:0]] <= cur_q.patch;
		if (rd_en) rd_s1 <= tab_q[idx_q[TIDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			idx_q <= '0;
			rd_ok_s1 <= 1'b0;
			p_q <= '0;
			ov_q <= 1'b0;
			res_q <= '0;
		end else begin
			state_q <= state_d;
			if (ov_q && out_ready) ov_q <= 1'b0;
			// a hit waiting for the output register keeps its compare
			rd_ok_s1 <= rd_en || (hit && !out_free);
			case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					p_q <= '0;
				end
				ST_SEARCH: begin
					if (count_q == CNT_W'(TONE_CAPACITY)) begin
						if (out_free) begin
							ov_q <= 1'b1;
							res_q <= '{KIND_FULL, cur_q.chan, 8'd0, 6'd0, 7'd0, 1'b1};
						end
					end else if (hit) begin
						if (out_free) begin
							ov_q <= 1'b1;
							res_q <= '{KIND_MATCH, cur_q.chan,
								8'(idx_q - CNT_W'(1)), 6'd0, 7'd0, 1'b1};
						end
					end else if (rd_en) begin
						idx_q <= idx_q + CNT_W'(1);
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						ov_q <= 1'b1;
						res_q <= '{KIND_NEW, cur_q.chan, 8'(count_q), p_q,
							cur_q.patch[p_q*7 +: 7], p_q == LAST_PARAM};
						p_q <= p_q + 6'd1;
						if (p_q == LAST_PARAM) count_q <= count_q + CNT_W'(1);
					end
				end
				default: ;
			endcase
		end
	end
endmodule
